[rtl/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants
// Round constants, initial hash values and the front/back queue entry type.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int QueueDepthDefault = 4;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       last;
   } item_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROUND,
      ST_SUM,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } core_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
         32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[r];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

endpackage

[rtl/sha_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front: input item queue
// Accepts items, drops those that carry neither a byte nor an end mark, and
// holds the rest in a small FIFO for the compression core.
// ----------------------------------------------------------------------------
module sha_front #(
   parameter int Depth = sha_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output sha_pkg::item_type out_item
);
   import sha_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   item_type          mem [Depth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem[rd_ff];
   assign push = in_valid && in_ready && (in_item.has_byte || in_item.last);
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= in_item;
   end

endmodule

[rtl/sha_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core: block buffer, SHA-256 round engine and digest output
// Loads bytes into the schedule window, runs one round a cycle, pads the
// final block(s) and presents the eight digest words through a register.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [31:0]       out_word,
   output logic [2:0]        out_index,
   output logic              out_last
);
   import sha_pkg::*;

   core_state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] msg_ff, msg_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;     // compressing the final block
   logic        pad_ff, pad_in;     // message ended, padding under way
   logic        pend_ff, pend_in;   // pad byte not yet written
   logic [2:0]  oidx_ff, oidx_in;

   logic        wr_en, start, wrap;
   logic [7:0]  wr_byte;
   logic [2:0]  len_sel;
   logic [63:0] bits;

   logic [31:0] w_cur, s0, s1, w_new, big0, big1, ch, maj, t1, t2;

   assign bits    = {msg_ff, 3'b000};
   // length bytes go to positions 56..63, low byte last
   assign len_sel = ~fill_ff[2:0];

   always_comb begin
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
           ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
           ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      w_cur = (rnd_ff < 6'd16) ? w_ff[0] : w_new;
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
             ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + round_k(rnd_ff) + w_cur;
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
             ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               if (in_item.has_byte && fill_ff == 6'd63) state_in = ST_ROUND;
               else if (in_item.last) state_in = ST_PAD;
            end
         end
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_SUM;
         ST_SUM: begin
            if (fin_ff) state_in = ST_OUT;
            else if (pad_ff) state_in = ST_PAD;
            else state_in = ST_LOAD;
         end
         ST_PAD: begin
            if (fill_ff == 6'd63) state_in = ST_ROUND;
            else if (fill_ff == LenPos - 6'd1) state_in = ST_LEN;
         end
         ST_LEN: if (fill_ff == 6'd63) state_in = ST_ROUND;
         ST_OUT: if (out_ready && oidx_ff == 3'd7) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      wr_en = 1'b0; start = 1'b0; wrap = 1'b0;
      wr_byte = in_item.byte_value;
      fill_in = fill_ff; msg_in = msg_ff; rnd_in = rnd_ff;
      fin_in = fin_ff; pad_in = pad_ff; pend_in = pend_ff; oidx_in = oidx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               if (in_item.last) begin
                  pad_in = 1'b1; pend_in = 1'b1;
               end
               if (in_item.has_byte) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  msg_in  = msg_ff + 61'd1;
                  if (fill_ff == 6'd63) begin
                     start = 1'b1; fin_in = 1'b0;
                  end
               end
            end
         end
         ST_ROUND: rnd_in = rnd_ff + 6'd1;
         ST_SUM: ;
         ST_PAD: begin
            // pad byte first, zero fill after
            wr_en = 1'b1; wr_byte = pend_ff ? PadByte : 8'h00; pend_in = 1'b0;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               start = 1'b1; fin_in = 1'b0;
            end
         end
         ST_LEN: begin
            wr_en = 1'b1;
            wr_byte = bits[{len_sel, 3'b000} +: 8];
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               start = 1'b1; fin_in = 1'b1; pad_in = 1'b0;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  wrap = 1'b1; fin_in = 1'b0; msg_in = '0;
               end
            end
         end
         default: ;
      endcase
      if (start) rnd_in = '0;
   end

   assign in_ready  = (state_ff == ST_LOAD);
   assign out_valid = (state_ff == ST_OUT);
   assign out_word  = h_ff[oidx_ff];
   assign out_index = oidx_ff;
   assign out_last  = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         msg_ff   <= '0;
         rnd_ff   <= '0;
         fin_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         msg_ff   <= msg_in;
         rnd_ff   <= rnd_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         pend_ff  <= pend_in;
         oidx_ff  <= oidx_in;
         if (state_ff == ST_SUM) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end else if (wrap) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
         end
      end
   end

   // schedule window: a new word opens at w_ff[15] every fourth byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (fill_ff[1:0] == 2'd0) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= {24'd0, wr_byte};
         end else begin
            w_ff[15] <= {w_ff[15][23:0], wr_byte};
         end
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

[rtl/sha256_byte_stream_hasher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit: SHA-256 over a byte stream
// Queue in front, compression core behind.
// ----------------------------------------------------------------------------
// One byte a cycle is taken while the core is loading; every 64th byte starts a
// compression (64 rounds at one per cycle, then a fold into the chaining hash),
// while the core takes no bytes. The end mark adds padding (up to 72 fill
// bytes, one byte a cycle), one or two compressions, and eight digest items on
// rsp_. A queue (four entries by default) absorbs items while the core works.
module sha256_byte_stream_hasher_unit #(
   parameter int QueueDepth = sha_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;
   logic [31:0] word;
   logic [2:0]  idx;

   assign in_item = '{byte_value: req_tdata, has_byte: req_tuser, last: req_tlast};

   sha_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   sha_core u_core (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(word), .out_index(idx), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'b0, idx, word};

endmodule

[rtl/sha_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker: port-level checks
// Digest word order and handshake holding on the result channel.
// ----------------------------------------------------------------------------
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last_word out of place");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("digest word skipped");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled item changed");
endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
